// ===== rtl/lcdt_pkg.sv =====
// Shared types, codes and mode lengths for the LCD mode timing controller.
// No dependencies; imported by lcdt_core and lcd_mode_timing_controller.
package lcdt_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;

    // STAT select bit positions
    localparam int STAT_MATCH_BIT  = 6;
    localparam int STAT_OAM_BIT    = 5;
    localparam int STAT_VBLANK_BIT = 4;
    localparam int STAT_HBLANK_BIT = 3;

    localparam logic [7:0] LEN_HBLANK   = 8'd51;
    localparam logic [7:0] LEN_VBLANK   = 8'd114;
    localparam logic [7:0] LEN_OAM      = 8'd20;
    localparam logic [7:0] LEN_XFER     = 8'd43;
    localparam logic [7:0] LAST_VISIBLE = 8'd143;
    localparam logic [7:0] LAST_LINE    = 8'd153;

    typedef struct packed {
        logic       op;
        logic [5:0] ticks;
        logic [3:0] reg_index;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        lcd_mode_t  lcd_mode;
        logic [7:0] current_line;
        logic       line_match;
        logic       vblank_irq;
        logic       stat_irq;
        logic       render_line_strobe;
        logic       frame_done;
    } result_t;

    function automatic logic [7:0] mode_len(input lcd_mode_t mode);
        logic [7:0] len;
        unique case (mode)
            MODE_HBLANK: len = LEN_HBLANK;
            MODE_VBLANK: len = LEN_VBLANK;
            MODE_OAM:    len = LEN_OAM;
            default:     len = LEN_XFER;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/lcdt_core.sv =====
// Mode/line state registers and the combinational update for one item.
// Depends on lcdt_pkg.
module lcdt_core
    import lcdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    lcd_mode_t  mode_reg, mode_next;
    logic [7:0] cycle_reg, cycle_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] cmp_reg, cmp_next;
    logic       en_match_reg, en_match_next;
    logic       en_oam_reg, en_oam_next;
    logic       en_vblank_reg, en_vblank_next;
    logic       en_hblank_reg, en_hblank_next;
    logic       match_reg, match_next;

    logic [8:0] sum_wide;
    logic [7:0] sum_sat;
    logic [7:0] sum_sub;
    logic [7:0] line_inc;
    logic       mode_done;
    logic       was_eq;
    logic       now_eq;
    logic       vblank_irq;
    logic       stat_irq;
    logic       strobe;
    logic       frame;

    always_comb
    begin
        sum_wide  = {1'b0, cycle_reg} + {3'b000, item.ticks};
        sum_sat   = sum_wide[8] ? 8'hFF : sum_wide[7:0];
        mode_done = (sum_sat >= mode_len(mode_reg));
        sum_sub   = sum_sat - mode_len(mode_reg);
        line_inc  = line_reg + 8'd1;
        was_eq    = (line_reg == cmp_reg);

        mode_next      = mode_reg;
        cycle_next     = cycle_reg;
        line_next      = line_reg;
        cmp_next       = cmp_reg;
        en_match_next  = en_match_reg;
        en_oam_next    = en_oam_reg;
        en_vblank_next = en_vblank_reg;
        en_hblank_next = en_hblank_reg;
        match_next     = match_reg;
        vblank_irq     = 1'b0;
        strobe         = 1'b0;
        frame          = 1'b0;
        stat_irq       = 1'b0;
        now_eq         = 1'b0;

        if (item.op == OP_WRITE)
        begin
            unique case (item.reg_index)
                REG_STAT:
                begin
                    en_match_next  = item.write_data[STAT_MATCH_BIT];
                    en_oam_next    = item.write_data[STAT_OAM_BIT];
                    en_vblank_next = item.write_data[STAT_VBLANK_BIT];
                    en_hblank_next = item.write_data[STAT_HBLANK_BIT];
                end
                REG_LY:  line_next = 8'd0;
                REG_LYC: cmp_next  = item.write_data;
                default: ;
            endcase
        end
        else
        begin
            cycle_next = mode_done ? sum_sub : sum_sat;
            if (mode_done)
            begin
                unique case (mode_reg)
                    MODE_HBLANK:
                    begin
                        line_next = line_inc;
                        if (line_reg == LAST_VISIBLE)
                        begin
                            mode_next  = MODE_VBLANK;
                            vblank_irq = 1'b1;
                            frame      = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_OAM;
                        end
                    end
                    MODE_VBLANK:
                    begin
                        // wrap of an 8-bit line after a reset in VBlank stays in VBlank
                        if (line_inc > LAST_LINE)
                        begin
                            line_next = 8'd0;
                            mode_next = MODE_OAM;
                        end
                        else
                        begin
                            line_next = line_inc;
                        end
                    end
                    MODE_OAM: mode_next = MODE_XFER;
                    default:
                    begin
                        mode_next = MODE_HBLANK;
                        strobe    = 1'b1;
                    end
                endcase
            end
            now_eq     = (line_next == cmp_reg);
            match_next = now_eq;
            stat_irq   = (en_match_reg && !was_eq && now_eq)
                       || (en_hblank_reg && mode_next == MODE_HBLANK)
                       || (en_vblank_reg && mode_next == MODE_VBLANK)
                       || (en_oam_reg && mode_next == MODE_OAM);
        end

        result.lcd_mode           = mode_next;
        result.current_line       = line_next;
        result.line_match         = match_next;
        result.vblank_irq         = vblank_irq;
        result.stat_irq           = stat_irq;
        result.render_line_strobe = strobe;
        result.frame_done         = frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HBLANK;
            cycle_reg     <= 8'd0;
            line_reg      <= 8'd0;
            cmp_reg       <= 8'd0;
            en_match_reg  <= 1'b0;
            en_oam_reg    <= 1'b0;
            en_vblank_reg <= 1'b0;
            en_hblank_reg <= 1'b0;
            match_reg     <= 1'b0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            cycle_reg     <= cycle_next;
            line_reg      <= line_next;
            cmp_reg       <= cmp_next;
            en_match_reg  <= en_match_next;
            en_oam_reg    <= en_oam_next;
            en_vblank_reg <= en_vblank_next;
            en_hblank_reg <= en_hblank_next;
            match_reg     <= match_next;
        end
    end

endmodule

// ===== rtl/lcd_mode_timing_controller.sv =====
// Top level: input register, result register and handshake control.
// Depends on lcdt_pkg and lcdt_core.

// Steps an LCD through OAM search, transfer, HBlank and VBlank from tick items
// and takes STAT, line-reset and compare-line writes on the same channel. Every
// item, tick or write, gives exactly one result. One item is taken per clock
// cycle while the input is not stalled. Each item is loaded into the input
// register at its transfer; the state update then feeds the result register
// when that register can load. The input side stalls only when the input
// register is full and the result register cannot drain.
module lcd_mode_timing_controller
    import lcdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [5:0] ticks,
    input  logic [3:0] reg_index,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] lcd_mode,
    output logic [7:0] current_line,
    output logic       line_match,
    output logic       vblank_irq,
    output logic       stat_irq,
    output logic       render_line_strobe,
    output logic       frame_done
);

    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    in_take;
    logic    out_load;

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    lcdt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (out_load),
        .item   (s1_item_reg),
        .result (res_next)
    );

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= '{op: op, ticks: ticks, reg_index: reg_index,
                             write_data: write_data};
        if (out_load)
            res_reg <= res_next;
    end

    assign out_valid          = out_valid_reg;
    assign lcd_mode           = res_reg.lcd_mode;
    assign current_line       = res_reg.current_line;
    assign line_match         = res_reg.line_match;
    assign vblank_irq         = res_reg.vblank_irq;
    assign stat_irq           = res_reg.stat_irq;
    assign render_line_strobe = res_reg.render_line_strobe;
    assign frame_done         = res_reg.frame_done;

    a_strobe_hblank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && render_line_strobe |-> lcd_mode == MODE_HBLANK)
        else $error("render strobe outside HBlank");

    a_frame_vblank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> vblank_irq && lcd_mode == MODE_VBLANK
                                    && current_line == LAST_VISIBLE + 8'd1)
        else $error("frame done without VBlank entry");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !s1_valid_reg |=> !out_valid)
        else $error("result repeated after transfer");

endmodule
